>>> rtl/min_priority_queue_defines.svh
// assertion helpers for the rtl files (used by min_priority_queue.sv)
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// clocked assertion, masked while reset is held
`define MPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/mpq_pkg.sv
`timescale 1ns / 1ps

package mpq_pkg;

    // number of cells in the chain
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;

    // operation codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // one held entry
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

>>> rtl/mpq_cell.sv
`timescale 1ns / 1ps

module mpq_cell (
    input  logic               i_clk,
    input  mpq_pkg::t_cell_ctl i_ctl,
    input  mpq_pkg::t_entry    i_new,
    input  mpq_pkg::t_entry    i_prev,
    input  logic               i_prev_ins,
    input  mpq_pkg::t_entry    i_next,
    input  logic               i_occ,
    output mpq_pkg::t_entry    o_entry,
    output logic               o_ins
);
    import mpq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    // new entry goes here or earlier when this slot is free or holds a larger key
    assign o_ins   = !i_occ || (r_ent.key > i_new.key);
    assign o_entry = r_ent;

    // shift down on insert, shift up on pop
    always_comb begin
        n_ent = r_ent;
        if (i_ctl.push) begin
            if (i_prev_ins) begin
                n_ent = i_prev;
            end else if (o_ins) begin
                n_ent = i_new;
            end
        end else if (i_ctl.pop) begin
            n_ent = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

>>> rtl/min_priority_queue.sv
// result path: an accepted request's status is registered, then moved into the output register
// throughput: one push or pop per cycle unless the output is stalled; the cell chain
// updates on acceptance and the result is then read from the chain into the output register
// reset: synchronous active low, empties the queue and drops any pending result;
// entry storage itself is not cleared
`timescale 1ns / 1ps
`include "min_priority_queue_defines.svh"

module min_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // key[31:0], value[63:32]
    input  logic [0:0]  i_s_tuser,  // func[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,  // front_value[31:0], back_value[63:32],
                                    // count[68:64], empty_res[69], zero pad[71:70]
    output logic [1:0]  o_m_tuser   // status[1:0]
);
    import mpq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_fin;
    logic [1:0]       r_fin_status;
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [VAL_W-1:0] r_out_front;
    logic [VAL_W-1:0] r_out_back;
    logic [CNT_W-1:0] r_out_count;

    logic             w_acc;
    logic             w_full;
    logic             w_empty;
    logic             w_do_push;
    logic             w_do_pop;
    logic             w_load;
    logic [1:0]       w_status;
    t_entry           w_new;
    t_cell_ctl        w_ctl;
    logic [VAL_W-1:0] w_front;
    logic [VAL_W-1:0] w_back;

    t_entry w_ent  [CAPACITY];
    t_entry w_prev [CAPACITY];
    t_entry w_next [CAPACITY];
    logic   w_ins  [CAPACITY];
    logic   w_pins [CAPACITY];
    logic   w_occ  [CAPACITY];
    logic   w_last [CAPACITY];

    // request decode
    assign w_acc     = i_s_tvalid && o_s_tready;
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_do_push = w_acc && (i_s_tuser[0] == FUNC_PUSH) && !w_full;
    assign w_do_pop  = w_acc && (i_s_tuser[0] == FUNC_POP) && !w_empty;
    assign w_new.key   = i_s_tdata[31:0];
    assign w_new.value = i_s_tdata[63:32];
    assign w_ctl.push  = w_do_push;
    assign w_ctl.pop   = w_do_pop;

    always_comb begin
        w_status = ST_DONE;
        if (i_s_tuser[0] == FUNC_PUSH) begin
            if (w_full) begin
                w_status = ST_FULL;
            end
        end else if (w_empty) begin
            w_status = ST_EMPTY;
        end
    end

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g] = (r_count > CNT_W'(g));
        if (g == 0) begin : g_head
            assign w_prev[g] = w_ent[g];
            assign w_pins[g] = 1'b0;
        end else begin : g_body
            assign w_prev[g] = w_ent[g-1];
            assign w_pins[g] = w_ins[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next[g] = w_ent[g];
            assign w_last[g] = w_occ[g];
        end else begin : g_inner
            assign w_next[g] = w_ent[g+1];
            assign w_last[g] = w_occ[g] && (r_count == CNT_W'(g + 1));
        end

        mpq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_new      (w_new),
            .i_prev     (w_prev[g]),
            .i_prev_ins (w_pins[g]),
            .i_next     (w_next[g]),
            .i_occ      (w_occ[g]),
            .o_entry    (w_ent[g]),
            .o_ins      (w_ins[g])
        );
    end

    // count update
    always_comb begin
        n_count = r_count;
        if (w_do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // front and back readout from the chain
    always_comb begin
        w_front = w_occ[0] ? w_ent[0].value : '0;
        w_back  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_back = w_back | (w_ent[i].value & {VAL_W{w_last[i]}});
        end
    end

    // result stage handshake
    assign w_load     = r_fin && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_fin || !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_fin <= 1'b1;
            end else if (w_load) begin
                r_fin <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_fin_status <= w_status;
        end
        if (w_load) begin
            r_out_status <= r_fin_status;
            r_out_front  <= w_front;
            r_out_back   <= w_back;
            r_out_count  <= r_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {2'b00, (r_out_count == '0), r_out_count, r_out_back, r_out_front};

    // checks
    `MPQ_ASSERT(a_count_range, r_count <= CNT_W'(CAPACITY), "held count beyond capacity")
    `MPQ_ASSERT(a_reject_holds, (w_acc && !w_do_push && !w_do_pop) |=> $stable(r_count),
        "rejected request changed the count")
    `MPQ_ASSERT(a_full_status, (w_load && (r_fin_status == ST_FULL)) |-> w_full,
        "full status with room left")
    `MPQ_ASSERT(a_empty_front, (w_load && w_empty) |-> (w_front == '0 && w_back == '0),
        "empty queue shows nonzero values")

endmodule
